FILE: rtl/core/scm_pkg.sv
// Shared types and codes for the sparse column union merge block.
package scm_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_MERGE       = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BOTH   = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_SECOND = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  localparam int PortRowBits = 16;
  localparam int ValueBits   = 64;
  localparam int TotalBits   = 32;

  typedef struct packed {
    logic [1:0]             mode;
    logic [PortRowBits-1:0] row;
    logic [ValueBits-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [PortRowBits-1:0] out_row;
    logic [ValueBits-1:0]   value_first;
    logic [ValueBits-1:0]   value_second;
    logic [1:0]             kind;
    logic                   last;
    logic [TotalBits-1:0]   total_entries;
    logic [TotalBits-1:0]   total_first_only;
    logic [TotalBits-1:0]   total_second_only;
    logic                   overflow;
  } result_t;

endpackage

FILE: rtl/core/scm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module scm_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sparse_column_union_merge_top.sv
// Sparse column union merge: two entry stores in RAM and a sorted-union walker.
// A load word never raises busy; a dropped load sets overflow.
// A merge word raises busy until its last result is made, one result per cycle;
// the merge sets the walk state register, and each result and its strobe are registered
// from the one read port of each store. An empty merge gives no results and no busy cycle.
// Reset clears counts, totals, overflow and control; store contents are not cleared.
module sparse_column_union_merge_top #(
  parameter int COLUMN_DEPTH = 32,
  parameter int ROW_BITS     = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  scm_pkg::cmd_t   cmd,
  output logic            strobe,
  output scm_pkg::result_t result
);

  localparam int RW = ROW_BITS < scm_pkg::PortRowBits ? ROW_BITS : scm_pkg::PortRowBits;
  localparam int EW = RW + scm_pkg::ValueBits;
  localparam int AW = $clog2(COLUMN_DEPTH > 1 ? COLUMN_DEPTH : 2);
  localparam int CW = $clog2(COLUMN_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(COLUMN_DEPTH);

  scm_pkg::state_t state, state_next;

  logic [CW-1:0] first_count, second_count;
  logic [CW-1:0] a_ptr, b_ptr, a_next, b_next;
  logic [scm_pkg::TotalBits-1:0] merged_total, first_only_total, second_only_total;
  logic [scm_pkg::TotalBits-1:0] merged_total_next, first_only_total_next;
  logic [scm_pkg::TotalBits-1:0] second_only_total_next;
  logic overflow_flag;

  logic accept, load_first, load_second, merge_cmd, merge_empty;
  logic we_first, we_second;
  logic [EW-1:0] wdata, rd_first, rd_second;
  logic [AW-1:0] raddr_first, raddr_second;

  logic have_a, have_b, take_a, take_b, walk_last;
  logic [RW-1:0] row_a, row_b;
  scm_pkg::result_t res_next;

  assign busy        = (state == scm_pkg::ST_WALK);
  assign accept      = start && !busy;
  assign load_first  = accept && (cmd.mode == scm_pkg::MODE_LOAD_FIRST);
  assign load_second = accept && (cmd.mode == scm_pkg::MODE_LOAD_SECOND);
  assign merge_cmd   = accept && (cmd.mode == scm_pkg::MODE_MERGE);
  assign merge_empty = (first_count == '0) && (second_count == '0);
  assign we_first    = load_first && (first_count < DepthC);
  assign we_second   = load_second && (second_count < DepthC);
  assign wdata       = {cmd.row[RW-1:0], cmd.value};

  scm_ram #(.WIDTH(EW), .DEPTH(COLUMN_DEPTH)) u_first_store (
    .clk   (clk),
    .we    (we_first),
    .waddr (first_count[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_first),
    .rdata (rd_first)
  );

  scm_ram #(.WIDTH(EW), .DEPTH(COLUMN_DEPTH)) u_second_store (
    .clk   (clk),
    .we    (we_second),
    .waddr (second_count[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_second),
    .rdata (rd_second)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      scm_pkg::ST_IDLE: begin
        if (merge_cmd && !merge_empty) begin
          state_next = scm_pkg::ST_WALK;
        end
      end
      scm_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = scm_pkg::ST_IDLE;
        end
      end
      default: state_next = scm_pkg::ST_IDLE;
    endcase
  end

  // Walk decision and result word
  always_comb begin
    row_a  = rd_first[EW-1:scm_pkg::ValueBits];
    row_b  = rd_second[EW-1:scm_pkg::ValueBits];
    have_a = a_ptr < first_count;
    have_b = b_ptr < second_count;
    take_a = 1'b0;
    take_b = 1'b0;
    if (have_a && have_b) begin
      if (row_a < row_b) begin
        take_a = 1'b1;
      end else if (row_a > row_b) begin
        take_b = 1'b1;
      end else begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
    end else if (have_a) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
    a_next    = a_ptr + CW'(take_a);
    b_next    = b_ptr + CW'(take_b);
    walk_last = (a_next >= first_count) && (b_next >= second_count);

    // While walking, fetch the heads that follow this step; otherwise hold the pointers.
    raddr_first  = busy ? a_next[AW-1:0] : a_ptr[AW-1:0];
    raddr_second = busy ? b_next[AW-1:0] : b_ptr[AW-1:0];

    merged_total_next      = merged_total + scm_pkg::TotalBits'(1);
    first_only_total_next  = first_only_total;
    second_only_total_next = second_only_total;
    if (take_a && !take_b) begin
      first_only_total_next = first_only_total + scm_pkg::TotalBits'(1);
    end
    if (take_b && !take_a) begin
      second_only_total_next = second_only_total + scm_pkg::TotalBits'(1);
    end

    res_next.out_row      = take_a ? scm_pkg::PortRowBits'(row_a)
                                   : scm_pkg::PortRowBits'(row_b);
    res_next.value_first  = take_a ? rd_first[scm_pkg::ValueBits-1:0] : '0;
    res_next.value_second = take_b ? rd_second[scm_pkg::ValueBits-1:0] : '0;
    priority if (take_a && take_b) begin
      res_next.kind = scm_pkg::KIND_BOTH;
    end else if (take_a) begin
      res_next.kind = scm_pkg::KIND_FIRST;
    end else begin
      res_next.kind = scm_pkg::KIND_SECOND;
    end
    res_next.last              = walk_last;
    res_next.total_entries     = merged_total_next;
    res_next.total_first_only  = first_only_total_next;
    res_next.total_second_only = second_only_total_next;
    res_next.overflow          = overflow_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= scm_pkg::ST_IDLE;
      first_count       <= '0;
      second_count      <= '0;
      a_ptr             <= '0;
      b_ptr             <= '0;
      merged_total      <= '0;
      first_only_total  <= '0;
      second_only_total <= '0;
      overflow_flag     <= 1'b0;
      strobe            <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= busy;
      if (we_first) begin
        first_count <= first_count + CW'(1);
      end
      if (we_second) begin
        second_count <= second_count + CW'(1);
      end
      if ((load_first && !we_first) || (load_second && !we_second)) begin
        overflow_flag <= 1'b1;
      end
      if (merge_cmd && merge_empty) begin
        overflow_flag <= 1'b0;
      end
      if (busy) begin
        merged_total      <= merged_total_next;
        first_only_total  <= first_only_total_next;
        second_only_total <= second_only_total_next;
        if (walk_last) begin
          // End of column: empty both stores and drop the flag.
          a_ptr         <= '0;
          b_ptr         <= '0;
          first_count   <= '0;
          second_count  <= '0;
          overflow_flag <= 1'b0;
        end else begin
          a_ptr <= a_next;
          b_ptr <= b_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_strobe_after_walk: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a walk step");

  a_walk_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> (a_ptr < first_count || b_ptr < second_count))
    else $error("walk running with both stores exhausted");

  a_last_ends_column: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> (first_count == '0 && second_count == '0 &&
                                 !overflow_flag && !busy))
    else $error("column not closed after last result");

  a_total_steps: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(strobe)) |-> (result.total_entries ==
                                   $past(result.total_entries) + 32'd1))
    else $error("merged total did not advance by one");
`endif

endmodule

FILE: bench/sparse_column_union_merge_top_test.sv
// Testbench for the sparse column union merge block: directed and random columns.
module sparse_column_union_merge_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth  = 32;
  localparam int SideFirst   = 0;
  localparam int SideSecond  = 1;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;
  localparam logic [1:0] ModeIgnored = 2'd3;

  typedef enum {SHAPE_SORTED, SHAPE_SHUFFLED, SHAPE_INTERLEAVED} col_shape_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  scm_pkg::cmd_t    cmd = '0;
  logic             busy;
  logic             strobe;
  scm_pkg::result_t result;

  sparse_column_union_merge_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  // Words waiting to be sent, and merged entries waiting to come out.
  scm_pkg::cmd_t    cmd_backlog[$];
  scm_pkg::result_t merged_expect[$];
  int      queued_words = 0;
  int      sender_idle_pct = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  // Predicted block state: two column stores, running totals, overflow.
  logic [15:0] col_row [2][StoreDepth];
  logic [63:0] col_val [2][StoreDepth];
  int          col_cnt [2] = '{0, 0};
  logic [31:0] sum_all = '0;
  logic [31:0] sum_first_only = '0;
  logic [31:0] sum_second_only = '0;
  logic        col_overflow = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic apply_command(scm_pkg::cmd_t c);
    int      side;
    int      ia;
    int      ib;
    logic    take_first;
    logic    take_second;
    scm_pkg::result_t e;
    ia = 0;
    ib = 0;
    case (c.mode)
      scm_pkg::MODE_LOAD_FIRST, scm_pkg::MODE_LOAD_SECOND: begin
        side = (c.mode == scm_pkg::MODE_LOAD_SECOND) ? SideSecond : SideFirst;
        if (col_cnt[side] < StoreDepth) begin
          col_row[side][col_cnt[side]] = c.row;
          col_val[side][col_cnt[side]] = c.value;
          col_cnt[side]++;
        end else begin
          col_overflow = 1'b1;
        end
      end
      scm_pkg::MODE_MERGE: begin
        while (ia < col_cnt[SideFirst] || ib < col_cnt[SideSecond]) begin
          e = '0;
          take_first = (ia < col_cnt[SideFirst]) && (ib >= col_cnt[SideSecond] ||
                       col_row[SideFirst][ia] < col_row[SideSecond][ib]);
          take_second = (ib < col_cnt[SideSecond]) && (ia >= col_cnt[SideFirst] ||
                        col_row[SideFirst][ia] > col_row[SideSecond][ib]);
          if (take_first) begin
            e.out_row = col_row[SideFirst][ia];
            e.value_first = col_val[SideFirst][ia];
            e.kind = scm_pkg::KIND_FIRST;
            sum_first_only++;
            ia++;
          end else if (take_second) begin
            e.out_row = col_row[SideSecond][ib];
            e.value_second = col_val[SideSecond][ib];
            e.kind = scm_pkg::KIND_SECOND;
            sum_second_only++;
            ib++;
          end else begin
            e.out_row = col_row[SideFirst][ia];
            e.value_first = col_val[SideFirst][ia];
            e.value_second = col_val[SideSecond][ib];
            e.kind = scm_pkg::KIND_BOTH;
            ia++;
            ib++;
          end
          sum_all++;
          e.last = (ia >= col_cnt[SideFirst] && ib >= col_cnt[SideSecond]);
          e.total_entries = sum_all;
          e.total_first_only = sum_first_only;
          e.total_second_only = sum_second_only;
          e.overflow = col_overflow;
          merged_expect.push_back(e);
        end
        // A merge closes the column, empty or not.
        col_cnt[SideFirst] = 0;
        col_cnt[SideSecond] = 0;
        col_overflow = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Driver: a word moves on an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(cmd);
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          cmd <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: every strobe carries one merged entry.
  always @(posedge clk) begin
    scm_pkg::result_t want;
    if (!rst && strobe) begin
      if (merged_expect.size() == 0) begin
        $error("unexpected result word: row %0h kind %0d", result.out_row, result.kind);
        mismatch_count++;
      end else begin
        want = merged_expect.pop_front();
        check_field("out_row", want.out_row, result.out_row);
        check_field("value_first", want.value_first, result.value_first);
        check_field("value_second", want.value_second, result.value_second);
        check_field("kind", want.kind, result.kind);
        check_field("last", want.last, result.last);
        check_field("total_entries", want.total_entries, result.total_entries);
        check_field("total_first_only", want.total_first_only, result.total_first_only);
        check_field("total_second_only", want.total_second_only,
                    result.total_second_only);
        check_field("overflow", want.overflow, result.overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] m, logic [15:0] r, logic [63:0] v);
    scm_pkg::cmd_t c;
    c.mode = m;
    c.row = r;
    c.value = v;
    cmd_backlog.push_back(c);
    if (m != ModeIgnored) queued_words++;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Build one column: loads for both stores, interleaved at random with occasional ignored words, then a merge.
  task automatic queue_column(int n_first, int n_second, col_shape_t shape);
    logic [15:0] rows_f[$];
    logic [15:0] rows_s[$];
    int          cursor;
    int          i_f;
    int          i_s;
    i_f = 0;
    i_s = 0;
    case (shape)
      SHAPE_SORTED: begin
        cursor = $urandom_range(65535 - 1200);
        while (rows_f.size() < n_first || rows_s.size() < n_second) begin
          cursor += $urandom_range(2, 1);
          if (rows_f.size() < n_first && $urandom_range(1) != 0)
            rows_f.push_back(cursor[15:0]);
          if (rows_s.size() < n_second && $urandom_range(1) != 0)
            rows_s.push_back(cursor[15:0]);
        end
      end
      SHAPE_SHUFFLED: begin
        // Out-of-order rows; a narrow range makes equal heads likely.
        for (int i = 0; i < n_first; i++)
          rows_f.push_back($urandom_range(1) != 0 ? 16'($urandom_range(15)) : 16'($urandom));
        for (int i = 0; i < n_second; i++)
          rows_s.push_back($urandom_range(1) != 0 ? 16'($urandom_range(15)) : 16'($urandom));
      end
      default: begin
        // Disjoint interleaved rows: every entry gives its own result.
        cursor = 2 * $urandom_range(32000);
        for (int i = 0; i < n_first; i++) rows_f.push_back(16'(cursor + 2 * i));
        for (int i = 0; i < n_second; i++) rows_s.push_back(16'(cursor + 2 * i + 1));
      end
    endcase
    while (i_f < rows_f.size() || i_s < rows_s.size()) begin
      if ($urandom_range(19) == 0) push_cmd(ModeIgnored, 16'($urandom), rand_value());
      if (i_s >= rows_s.size() || (i_f < rows_f.size() && $urandom_range(1) != 0)) begin
        push_cmd(scm_pkg::MODE_LOAD_FIRST, rows_f[i_f], rand_value());
        i_f++;
      end else begin
        push_cmd(scm_pkg::MODE_LOAD_SECOND, rows_s[i_s], rand_value());
        i_s++;
      end
    end
    push_cmd(scm_pkg::MODE_MERGE, 16'($urandom), rand_value());
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || merged_expect.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int phase_idle[3];
    int phase_words[3];
    int target;
    int pick;
    phase_idle = '{23, 64, 0};
    phase_words = '{6, 4, 14};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = phase_idle[p];
      if (p == 0) begin
        // Empty column: nothing comes out.
        push_cmd(scm_pkg::MODE_MERGE, 16'hffff, '1);
        // Mixed column with extreme rows and values.
        push_cmd(scm_pkg::MODE_LOAD_FIRST, 16'h0000, 64'h0);
        push_cmd(scm_pkg::MODE_LOAD_FIRST, 16'h0005, '1);
        push_cmd(scm_pkg::MODE_LOAD_SECOND, 16'h0005, 64'ha5a5_a5a5_a5a5_a5a5);
        push_cmd(ModeIgnored, 16'h1234, 64'hdead_beef_0000_0001);
        push_cmd(scm_pkg::MODE_LOAD_SECOND, 16'h0007, 64'h5a5a_5a5a_5a5a_5a5a);
        push_cmd(scm_pkg::MODE_LOAD_FIRST, 16'hffff, 64'h8000_0000_0000_0001);
        push_cmd(scm_pkg::MODE_MERGE, 16'h0000, '0);
        // Second side only.
        push_cmd(scm_pkg::MODE_LOAD_SECOND, 16'h0003, 64'h0123_4567_89ab_cdef);
        push_cmd(scm_pkg::MODE_LOAD_SECOND, 16'h0009, 64'hfedc_ba98_7654_3210);
        push_cmd(scm_pkg::MODE_MERGE, '0, '0);
        // First side only.
        push_cmd(scm_pkg::MODE_LOAD_FIRST, 16'h0001, 64'h7fff_ffff_ffff_fffe);
        push_cmd(scm_pkg::MODE_MERGE, '0, '0);
        // Rows out of order on both sides.
        push_cmd(scm_pkg::MODE_LOAD_FIRST, 16'h000a, 64'h1111);
        push_cmd(scm_pkg::MODE_LOAD_FIRST, 16'h0004, 64'h2222);
        push_cmd(scm_pkg::MODE_LOAD_SECOND, 16'h0004, 64'h3333);
        push_cmd(scm_pkg::MODE_LOAD_SECOND, 16'h000a, 64'h4444);
        push_cmd(scm_pkg::MODE_MERGE, '0, '0);
        // Hold off until the directed columns are fully out.
        wait_drained();
      end
      if (p == 1) begin
        // Both stores over-filled: drops, overflow, and the longest merge.
        queue_column(StoreDepth + 1, StoreDepth + $urandom_range(2, 1), SHAPE_INTERLEAVED);
      end
      target = queued_words + phase_words[p];
      while (queued_words < target) begin
        pick = $urandom_range(99);
        if (pick < 70)
          queue_column($urandom_range(6), $urandom_range(6), SHAPE_SORTED);
        else if (pick < 85)
          queue_column($urandom_range(5), $urandom_range(5), SHAPE_SHUFFLED);
        else
          queue_column($urandom_range(12), $urandom_range(12), SHAPE_SORTED);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/scm_pkg.sv
rtl/core/scm_ram.sv
rtl/core/sparse_column_union_merge_top.sv
bench/sparse_column_union_merge_top_test.sv
